// ----- hw/rtl/tps_pkg.sv -----
// Package: shared types and constants of the three-level task scheduler.
package tps_pkg;

    localparam int NUM_CLASS = 3;
    localparam int ID_W      = 16;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 32;
    localparam int QUANT_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CLASS_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_C = 2'd2;

    localparam logic [QUANT_W-1:0] QUANTUM_A_RST = 8'd2;
    localparam logic [QUANT_W-1:0] QUANTUM_B_RST = 8'd4;
    localparam logic [QUANT_W-1:0] QUANTUM_C_RST = 8'd8;
    localparam logic [QUANT_W-1:0] SLICE_MAX     = 8'hFF;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] remaining;
        logic               started;
        logic [TIME_W-1:0]  start_time;
    } tps_entry_t;

    typedef struct packed {
        logic capture;
        logic arrive;
        logic pick_clr;
        logic rd_issue;
        logic load;
        logic push_run;
        logic swap;
        logic consume;
        logic out_load;
    } tps_cmd_t;

    typedef struct packed {
        logic run_valid;
        logic pick_empty;
        logic higher_waiting;
        logic slice_expired;
        logic run_q_full;
        logic highest_is_run;
        logic done_now;
        logic out_free;
    } tps_status_t;

endpackage

// ----- hw/rtl/tps_if.sv -----
// Interfaces: input and result channels of the task scheduler.
interface tps_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [1:0]  task_class;
    logic [15:0] task_id;
    logic [15:0] burst_length;

    modport source (output valid, operation, task_class, task_id, burst_length, input ready);
    modport sink   (input valid, operation, task_class, task_id, burst_length, output ready);
endinterface

interface tps_out_if;
    logic        valid;
    logic        ready;
    logic        running_valid;
    logic [15:0] running_id;
    logic [1:0]  running_class;
    logic        done_valid;
    logic [15:0] done_id;
    logic [31:0] done_start_time;
    logic [31:0] done_finish_time;
    logic        arrival_dropped;

    modport source (output valid, running_valid, running_id, running_class, done_valid,
                    done_id, done_start_time, done_finish_time, arrival_dropped,
                    input ready);
    modport sink   (input valid, running_valid, running_id, running_class, done_valid,
                    done_id, done_start_time, done_finish_time, arrival_dropped,
                    output ready);
endinterface

// ----- hw/rtl/three_level_preemptive_task_scheduler.sv -----
// Top level: three-level preemptive task scheduler, one tick per input word.
// Each accepted word runs through the controller sequence (arrival, pick, preemption,
// rotation, completion), with one RAM read per pick; the result word then waits while
// the previous result word is still held in the output register.
// The next word is taken only once the result is registered. Reset: asynchronous
// active low; queues empty, no task running, counters zero, quanta 2, 4 and 8.
// Queue RAM contents are undefined until written.
module three_level_preemptive_task_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tps_in_if.sink      in_ch,
    tps_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    tps_pkg::tps_cmd_t    cmd;
    tps_pkg::tps_status_t status;

    tps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tps_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .in_operation         (in_ch.operation),
        .in_task_class        (in_ch.task_class),
        .in_task_id           (in_ch.task_id),
        .in_burst_length      (in_ch.burst_length),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .out_valid            (out_ch.valid),
        .out_ready            (out_ch.ready),
        .out_running_valid    (out_ch.running_valid),
        .out_running_id       (out_ch.running_id),
        .out_running_class    (out_ch.running_class),
        .out_done_valid       (out_ch.done_valid),
        .out_done_id          (out_ch.done_id),
        .out_done_start_time  (out_ch.done_start_time),
        .out_done_finish_time (out_ch.done_finish_time),
        .out_arrival_dropped  (out_ch.arrival_dropped)
    );

endmodule

// ----- hw/rtl/tps_ram.sv -----
// Generic RAM: one write port, one read port with registered read data.
module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/tps_ctrl.sv -----
// Controller: sequences arrival, pick, preemption, rotation and completion of one tick.
module tps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tps_pkg::tps_status_t status,
    output tps_pkg::tps_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ARR, S_CHK0, S_CHK1, S_CHK2, S_REQ,
        S_PICK, S_LOAD, S_SWAP, S_CONS, S_FIN
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ARR;
                end
            end
            S_ARR:
            begin
                cmd.arrive = 1'b1;
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                if (!status.run_valid)
                begin
                    state_next = S_PICK;
                    ret_next   = S_CHK1;
                end
                else
                begin
                    state_next = S_CHK1;
                end
            end
            S_CHK1:
            begin
                if (status.run_valid && status.higher_waiting)
                begin
                    state_next = S_REQ;
                    ret_next   = S_CHK2;
                end
                else
                begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                if (status.run_valid && status.slice_expired)
                begin
                    state_next = S_REQ;
                    ret_next   = S_CONS;
                end
                else
                begin
                    state_next = S_CONS;
                end
            end
            S_REQ:
            begin
                if (!status.run_q_full)
                begin
                    cmd.push_run = 1'b1;
                    state_next   = S_PICK;
                end
                else if (status.highest_is_run)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_SWAP;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_PICK:
            begin
                cmd.pick_clr = 1'b1;
                if (!status.pick_empty)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_LOAD;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ret_reg;
            end
            S_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ret_reg;
            end
            S_CONS:
            begin
                cmd.consume = 1'b1;
                if (status.done_now)
                begin
                    state_next = S_PICK;
                    ret_next   = S_FIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tps_dp.sv -----
// Datapath: class queues, running task, counters, quantum registers and result register.
module tps_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tps_pkg::tps_cmd_t    cmd,
    output tps_pkg::tps_status_t status,
    input  logic                 in_operation,
    input  logic [1:0]           in_task_class,
    input  logic [15:0]          in_task_id,
    input  logic [15:0]          in_burst_length,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_running_valid,
    output logic [15:0]          out_running_id,
    output logic [1:0]           out_running_class,
    output logic                 out_done_valid,
    output logic [15:0]          out_done_id,
    output logic [31:0]          out_done_start_time,
    output logic [31:0]          out_done_finish_time,
    output logic                 out_arrival_dropped
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = $bits(tps_pkg::tps_entry_t);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic                          arr_op_reg;
    logic [1:0]                    arr_cls_reg;
    logic [15:0]                   arr_id_reg;
    logic [15:0]                   arr_burst_reg;
    logic [tps_pkg::QUANT_W-1:0]   qa_reg, qb_reg, qc_reg;
    logic [PTR_W-1:0]              head_reg [tps_pkg::NUM_CLASS];
    logic [PTR_W-1:0]              tail_reg [tps_pkg::NUM_CLASS];
    logic [CNT_W-1:0]              count_reg [tps_pkg::NUM_CLASS];
    logic                          run_valid_reg;
    logic [1:0]                    run_class_reg;
    tps_pkg::tps_entry_t           run_reg;
    logic [tps_pkg::QUANT_W-1:0]   slice_reg;
    logic [31:0]                   tick_reg;
    logic [1:0]                    pick_cls_reg;
    logic                          done_valid_reg;
    logic [15:0]                   done_id_reg;
    logic [31:0]                   done_start_reg;
    logic [31:0]                   done_finish_reg;
    logic                          drop_reg;
    logic                          out_valid_reg;
    logic                          o_run_valid_reg;
    logic [15:0]                   o_run_id_reg;
    logic [1:0]                    o_run_class_reg;
    logic                          o_done_valid_reg;
    logic [15:0]                   o_done_id_reg;
    logic [31:0]                   o_done_start_reg;
    logic [31:0]                   o_done_finish_reg;
    logic                          o_drop_reg;

    logic [1:0]                    highest;
    logic                          arr_ok;
    logic [tps_pkg::QUANT_W-1:0]   q_sel;
    logic [tps_pkg::QUANT_W-1:0]   q_eff;
    logic [15:0]                   rem_dec;
    tps_pkg::tps_entry_t           arr_entry;
    tps_pkg::tps_entry_t           wr_entry;
    tps_pkg::tps_entry_t           rd_entry;
    logic [ENT_W-1:0]              rdata [tps_pkg::NUM_CLASS];
    logic                          push_c [tps_pkg::NUM_CLASS];
    logic                          pop_c [tps_pkg::NUM_CLASS];
    logic                          swap_c [tps_pkg::NUM_CLASS];

    always_comb
    begin
        priority if (count_reg[0] != '0)
            highest = 2'd0;
        else if (count_reg[1] != '0)
            highest = 2'd1;
        else if (count_reg[2] != '0)
            highest = 2'd2;
        else
            highest = tps_pkg::CLASS_NONE;
    end

    assign arr_ok = arr_op_reg && (arr_cls_reg != tps_pkg::CLASS_NONE);

    always_comb
    begin
        unique case (run_class_reg)
            2'd0:    q_sel = qa_reg;
            2'd1:    q_sel = qb_reg;
            default: q_sel = qc_reg;
        endcase
    end

    assign q_eff   = (q_sel == '0) ? tps_pkg::QUANT_W'(1) : q_sel;
    assign rem_dec = run_reg.remaining - 16'((run_reg.remaining != '0) ? 1 : 0);

    assign status.run_valid      = run_valid_reg;
    assign status.pick_empty     = (highest == tps_pkg::CLASS_NONE);
    assign status.higher_waiting = (highest < run_class_reg);
    assign status.slice_expired  = (slice_reg >= q_eff);
    assign status.run_q_full     = (count_reg[run_class_reg] == CNT_FULL);
    assign status.highest_is_run = (highest == run_class_reg);
    assign status.done_now       = run_valid_reg && (rem_dec == '0);
    assign status.out_free       = !out_valid_reg || out_ready;

    always_comb
    begin
        arr_entry.id         = arr_id_reg;
        arr_entry.remaining  = (arr_burst_reg == '0) ? 16'd1 : arr_burst_reg;
        arr_entry.started    = 1'b0;
        arr_entry.start_time = '0;
    end

    assign wr_entry = cmd.arrive ? arr_entry : run_reg;
    assign rd_entry = tps_pkg::tps_entry_t'(rdata[pick_cls_reg]);

    for (genvar i = 0; i < tps_pkg::NUM_CLASS; i++)
    begin : g_queue
        assign push_c[i] = (cmd.arrive && arr_ok && (count_reg[i] != CNT_FULL)
                            && (arr_cls_reg == 2'(i)))
                           || (cmd.push_run && (run_class_reg == 2'(i)));
        assign pop_c[i]  = cmd.load && (pick_cls_reg == 2'(i));
        assign swap_c[i] = cmd.swap && (pick_cls_reg == 2'(i));

        tps_ram #(
            .WIDTH (ENT_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (push_c[i] || swap_c[i]),
            .waddr (tail_reg[i]),
            .wdata (wr_entry),
            .re    (cmd.rd_issue && (highest == 2'(i))),
            .raddr (head_reg[i]),
            .rdata (rdata[i])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            else
            begin
                if (push_c[i] || swap_c[i])
                begin
                    tail_reg[i] <= (tail_reg[i] == PTR_LAST) ? '0 : tail_reg[i] + 1'b1;
                end
                if (pop_c[i] || swap_c[i])
                begin
                    head_reg[i] <= (head_reg[i] == PTR_LAST) ? '0 : head_reg[i] + 1'b1;
                end
                if (push_c[i])
                begin
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
                else if (pop_c[i])
                begin
                    count_reg[i] <= count_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            arr_op_reg    <= in_operation;
            arr_cls_reg   <= in_task_class;
            arr_id_reg    <= in_task_id;
            arr_burst_reg <= in_burst_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= tps_pkg::QUANTUM_A_RST;
            qb_reg <= tps_pkg::QUANTUM_B_RST;
            qc_reg <= tps_pkg::QUANTUM_C_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tps_pkg::REG_QUANTUM_A)
                qa_reg <= cfg_data;
            if (cfg_index == tps_pkg::REG_QUANTUM_B)
                qb_reg <= cfg_data;
            if (cfg_index == tps_pkg::REG_QUANTUM_C)
                qc_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg   <= 1'b0;
            run_class_reg   <= '0;
            run_reg         <= '0;
            slice_reg       <= '0;
            tick_reg        <= '0;
            pick_cls_reg    <= '0;
            done_valid_reg  <= 1'b0;
            done_id_reg     <= '0;
            done_start_reg  <= '0;
            done_finish_reg <= '0;
            drop_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                drop_reg <= 1'b0;
            end
            if (cmd.arrive && arr_ok && (count_reg[arr_cls_reg] == CNT_FULL))
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.rd_issue)
            begin
                pick_cls_reg <= highest;
            end
            if (cmd.pick_clr)
            begin
                run_valid_reg <= 1'b0;
                slice_reg     <= '0;
            end
            if (cmd.load)
            begin
                run_valid_reg <= 1'b1;
                run_class_reg <= pick_cls_reg;
                run_reg       <= rd_entry;
            end
            if (cmd.swap)
            begin
                run_reg   <= rd_entry;
                slice_reg <= '0;
            end
            if (cmd.consume)
            begin
                if (run_valid_reg)
                begin
                    run_reg.started   <= 1'b1;
                    run_reg.remaining <= rem_dec;
                    if (!run_reg.started)
                        run_reg.start_time <= tick_reg;
                end
                if (slice_reg != tps_pkg::SLICE_MAX)
                    slice_reg <= slice_reg + 1'b1;
                tick_reg        <= tick_reg + 1'b1;
                done_valid_reg  <= status.done_now;
                done_id_reg     <= run_reg.id;
                done_start_reg  <= run_reg.started ? run_reg.start_time : tick_reg;
                done_finish_reg <= tick_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_run_valid_reg   <= run_valid_reg;
            o_run_id_reg      <= run_valid_reg ? run_reg.id : '0;
            o_run_class_reg   <= run_valid_reg ? run_class_reg : '0;
            o_done_valid_reg  <= done_valid_reg;
            o_done_id_reg     <= done_valid_reg ? done_id_reg : '0;
            o_done_start_reg  <= done_valid_reg ? done_start_reg : '0;
            o_done_finish_reg <= done_valid_reg ? done_finish_reg : '0;
            o_drop_reg        <= drop_reg;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_running_valid    = o_run_valid_reg;
    assign out_running_id       = o_run_id_reg;
    assign out_running_class    = o_run_class_reg;
    assign out_done_valid       = o_done_valid_reg;
    assign out_done_id          = o_done_id_reg;
    assign out_done_start_time  = o_done_start_reg;
    assign out_done_finish_time = o_done_finish_reg;
    assign out_arrival_dropped  = o_drop_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= CNT_FULL && count_reg[1] <= CNT_FULL && count_reg[2] <= CNT_FULL)
        else $error("queue count above depth");
    a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load || cmd.swap) |-> $past(cmd.rd_issue))
        else $error("queue entry used without a read");
    a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> run_valid_reg)
        else $error("pick left no running task");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result word not presented");
`endif

endmodule

// ----- sim/three_level_preemptive_task_scheduler_test.sv -----
// Testbench: directed and random self-checking regression of the task scheduler.
`timescale 1ns / 100ps

module three_level_preemptive_task_scheduler_test;

    localparam int QD = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 400;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;
    localparam logic [1:0] CLASS_A = 2'd0;
    localparam logic [1:0] CLASS_B = 2'd1;
    localparam logic [1:0] CLASS_C = 2'd2;

    typedef struct {
        bit        op;
        bit [1:0]  cls;
        bit [15:0] id;
        bit [15:0] burst;
    } task_word_t;

    typedef struct {
        bit        run_v;
        bit [15:0] run_id;
        bit [1:0]  run_cls;
        bit        done_v;
        bit [15:0] done_id;
        bit [31:0] done_start;
        bit [31:0] done_finish;
        bit        dropped;
    } sched_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    tps_in_if  in_ch ();
    tps_out_if out_ch ();

    three_level_preemptive_task_scheduler #(.QUEUE_DEPTH(QD)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task_word_t  task_backlog[$];
    sched_word_t sched_expected[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          hold_req = 0;

    // scheduler shadow state
    bit [15:0] fq_id      [3][QD];
    bit [15:0] fq_rem     [3][QD];
    bit        fq_started [3][QD];
    bit [31:0] fq_stime   [3][QD];
    int        fq_head[3], fq_tail[3], fq_count[3];
    bit        cur_v;
    bit [15:0] cur_id;
    bit [1:0]  cur_cls;
    bit [15:0] cur_rem;
    bit        cur_started;
    bit [31:0] cur_stime;
    bit [7:0]  slice_cnt;
    bit [31:0] tick_cnt;
    bit [7:0]  quantum[3];

    function automatic void fq_push(int c, bit [15:0] id, bit [15:0] rem, bit st,
                                    bit [31:0] stime);
        fq_id[c][fq_tail[c]]      = id;
        fq_rem[c][fq_tail[c]]     = rem;
        fq_started[c][fq_tail[c]] = st;
        fq_stime[c][fq_tail[c]]   = stime;
        fq_tail[c] = (fq_tail[c] + 1) % QD;
        fq_count[c]++;
    endfunction

    function automatic void fq_pop_to_cur(int c);
        cur_v       = 1;
        cur_cls     = c[1:0];
        cur_id      = fq_id[c][fq_head[c]];
        cur_rem     = fq_rem[c][fq_head[c]];
        cur_started = fq_started[c][fq_head[c]];
        cur_stime   = fq_stime[c][fq_head[c]];
        fq_head[c] = (fq_head[c] + 1) % QD;
        fq_count[c]--;
    endfunction

    function automatic int top_waiting();
        for (int c = 0; c < 3; c++)
            if (fq_count[c] != 0)
                return c;
        return 3;
    endfunction

    function automatic void pick_next();
        int c;
        c = top_waiting();
        cur_v = 0;
        if (c < 3)
            fq_pop_to_cur(c);
        slice_cnt = 0;
    endfunction

    function automatic void rotate_cur();
        int c;
        bit [15:0] id, rem;
        bit st;
        bit [31:0] stime;
        c = int'(cur_cls);
        id = cur_id;
        rem = cur_rem;
        st = cur_started;
        stime = cur_stime;
        if (fq_count[c] < QD) begin
            fq_push(c, id, rem, st, stime);
            pick_next();
        end else if (top_waiting() == c) begin
            fq_pop_to_cur(c);
            fq_push(c, id, rem, st, stime);
            slice_cnt = 0;
        end
    endfunction

    function automatic sched_word_t schedule_tick(task_word_t w);
        sched_word_t r;
        bit [7:0] q;
        r = '{default: 0};
        if (w.op == OP_ARRIVE && w.cls != tps_pkg::CLASS_NONE) begin
            if (fq_count[w.cls] >= QD)
                r.dropped = 1;
            else
                fq_push(int'(w.cls), w.id, (w.burst == 0) ? 16'd1 : w.burst, 0, 0);
        end
        if (!cur_v)
            pick_next();
        if (cur_v && top_waiting() < int'(cur_cls))
            rotate_cur();
        if (cur_v) begin
            q = (quantum[cur_cls] == 0) ? 8'd1 : quantum[cur_cls];
            if (slice_cnt >= q)
                rotate_cur();
        end
        if (cur_v) begin
            if (!cur_started) begin
                cur_started = 1;
                cur_stime = tick_cnt;
            end
            if (cur_rem != 0)
                cur_rem--;
        end
        if (slice_cnt < tps_pkg::SLICE_MAX)
            slice_cnt++;
        tick_cnt++;
        if (cur_v && cur_rem == 0) begin
            r.done_v = 1;
            r.done_id = cur_id;
            r.done_start = cur_stime;
            r.done_finish = tick_cnt;
            pick_next();
        end
        r.run_v = cur_v;
        r.run_id = cur_v ? cur_id : 16'd0;
        r.run_cls = cur_v ? cur_cls : 2'd0;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("three_level_preemptive_task_scheduler regression: fail");
            $finish;
        end
    end

    // sender
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        task_word_t w;
        if (!rst_n) begin
            in_ch.valid <= 0;
            in_ch.operation <= 0;
            in_ch.task_class <= 0;
            in_ch.task_id <= 0;
            in_ch.burst_length <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                w.op = in_ch.operation;
                w.cls = in_ch.task_class;
                w.id = in_ch.task_id;
                w.burst = in_ch.burst_length;
                sched_expected.push_back(schedule_tick(w));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (burst_left > 0 && task_backlog.size() > 0) begin
                    w = task_backlog.pop_front();
                    in_ch.valid <= 1;
                    in_ch.operation <= w.op;
                    in_ch.task_class <= w.cls;
                    in_ch.task_id <= w.id;
                    in_ch.burst_length <= w.burst;
                    burst_left--;
                end else begin
                    in_ch.valid <= 0;
                    if (gap_left > 0)
                        gap_left--;
                    else if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver
    int  hold_cnt = 0;
    bit  hold_seen = 0;
    int  stall_mode = 0;
    int  mode_cnt = 0;
    bit [7:0] stall_pat = 8'hA5;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 0;
        else begin
            stall_pat <= {stall_pat[6:0], stall_pat[7]};
            if (mode_cnt == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_cnt <= $urandom_range(50, 300);
            end else
                mode_cnt <= mode_cnt - 1;
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_cnt <= LONG_HOLD;
                out_ch.ready <= 0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                out_ch.ready <= 0;
            end else if (stall_mode == 0)
                out_ch.ready <= 1;
            else if (stall_mode == 1)
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                out_ch.ready <= stall_pat[0];
        end
    end

    // result checker
    always @(posedge clk)
    begin
        sched_word_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (sched_expected.size() == 0) begin
                $error("unexpected result word");
                fail_count++;
            end else begin
                e = sched_expected.pop_front();
                if (out_ch.running_valid !== e.run_v) begin
                    $error("running_valid exp %0d got %0d", e.run_v, out_ch.running_valid);
                    fail_count++;
                end
                if (out_ch.running_id !== e.run_id) begin
                    $error("running_id exp %0h got %0h", e.run_id, out_ch.running_id);
                    fail_count++;
                end
                if (out_ch.running_class !== e.run_cls) begin
                    $error("running_class exp %0d got %0d", e.run_cls, out_ch.running_class);
                    fail_count++;
                end
                if (out_ch.done_valid !== e.done_v) begin
                    $error("done_valid exp %0d got %0d", e.done_v, out_ch.done_valid);
                    fail_count++;
                end
                if (out_ch.done_id !== e.done_id) begin
                    $error("done_id exp %0h got %0h", e.done_id, out_ch.done_id);
                    fail_count++;
                end
                if (out_ch.done_start_time !== e.done_start) begin
                    $error("done_start_time exp %0d got %0d", e.done_start,
                           out_ch.done_start_time);
                    fail_count++;
                end
                if (out_ch.done_finish_time !== e.done_finish) begin
                    $error("done_finish_time exp %0d got %0d", e.done_finish,
                           out_ch.done_finish_time);
                    fail_count++;
                end
                if (out_ch.arrival_dropped !== e.dropped) begin
                    $error("arrival_dropped exp %0d got %0d", e.dropped,
                           out_ch.arrival_dropped);
                    fail_count++;
                end
            end
        end
    end

    function automatic void queue_task(bit op, bit [1:0] cls, bit [15:0] id, bit [15:0] burst);
        task_word_t w;
        w.op = op;
        w.cls = cls;
        w.id = id;
        w.burst = burst;
        task_backlog.push_back(w);
    endfunction

    function automatic bit [15:0] rand_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'($urandom_range(0, 65535));
        else if (r < 15)
            return 16'($urandom_range(9, 60));
        return 16'($urandom_range(0, 8));
    endfunction

    function automatic void queue_random(int n);
        int k;
        int r;
        bit [1:0] cls;
        k = 0;
        while (k < n) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // flood one class with 20 short tasks, more than the queue depth
                cls = 2'($urandom_range(0, 2));
                for (int i = 0; i < 20; i++)
                    queue_task(OP_ARRIVE, cls, 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 3)));
                k += 20;
            end else begin
                if (r < 55) begin
                    cls = ($urandom_range(0, 19) == 0) ? tps_pkg::CLASS_NONE
                                                       : 2'($urandom_range(0, 2));
                    queue_task(OP_ARRIVE, cls, 16'($urandom_range(0, 65535)), rand_burst());
                end else
                    queue_task(OP_TICK, 2'($urandom_range(0, 3)),
                               16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)));
                k++;
            end
        end
    endfunction

    task automatic wait_idle();
        while (task_backlog.size() != 0 || in_ch.valid || sched_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_quanta(bit [7:0] qa, bit [7:0] qb, bit [7:0] qc);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= tps_pkg::REG_QUANTUM_A;
        cfg_data <= qa;
        @(posedge clk);
        cfg_index <= tps_pkg::REG_QUANTUM_B;
        cfg_data <= qb;
        @(posedge clk);
        cfg_index <= tps_pkg::REG_QUANTUM_C;
        cfg_data <= qc;
        @(posedge clk);
        cfg_we <= 0;
        quantum[0] = qa;
        quantum[1] = qb;
        quantum[2] = qc;
    endtask

    initial
    begin
        for (int c = 0; c < 3; c++)
        begin
            fq_head[c] = 0;
            fq_tail[c] = 0;
            fq_count[c] = 0;
        end
        cur_v = 0;
        cur_id = 0;
        cur_cls = 0;
        cur_rem = 0;
        cur_started = 0;
        cur_stime = 0;
        slice_cnt = 0;
        tick_cnt = 0;
        quantum[0] = tps_pkg::QUANTUM_A_RST;
        quantum[1] = tps_pkg::QUANTUM_B_RST;
        quantum[2] = tps_pkg::QUANTUM_C_RST;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, preemption, ignored class, zero burst
        queue_task(OP_TICK, CLASS_A, 16'h0000, 16'h0000);
        queue_task(OP_ARRIVE, CLASS_A, 16'h0000, 16'h0000);
        queue_task(OP_ARRIVE, CLASS_C, 16'hFFFF, 16'hFFFF);
        queue_task(OP_ARRIVE, CLASS_B, 16'h1234, 16'd3);
        queue_task(OP_ARRIVE, CLASS_A, 16'h00A1, 16'd5);
        queue_task(OP_ARRIVE, tps_pkg::CLASS_NONE, 16'hBEEF, 16'd2);
        queue_task(OP_ARRIVE, CLASS_A, 16'h00A2, 16'd1);
        queue_task(OP_TICK, tps_pkg::CLASS_NONE, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 14; i++)
            queue_task(OP_TICK, CLASS_A, 16'd0, 16'd0);
        wait_idle();

        write_quanta(8'd1, 8'd1, 8'd1);
        hold_req = ~hold_req;
        queue_random(280);
        wait_idle();

        write_quanta(8'd255, 8'd255, 8'd255);
        queue_random(280);
        wait_idle();

        write_quanta(8'd0, 8'd3, 8'd200);
        queue_random(280);
        wait_idle();

        write_quanta(tps_pkg::QUANTUM_A_RST, tps_pkg::QUANTUM_B_RST, tps_pkg::QUANTUM_C_RST);
        hold_req = ~hold_req;
        queue_random(280);
        wait_idle();

        for (int p = 0; p < 2; p++)
        begin
            write_quanta(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(1, 255)));
            queue_random(280);
            wait_idle();
        end

        if (fail_count == 0)
            $display("three_level_preemptive_task_scheduler regression: pass");
        else
            $display("three_level_preemptive_task_scheduler regression: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/tps_pkg.sv
hw/rtl/tps_if.sv
hw/rtl/tps_ram.sv
hw/rtl/tps_ctrl.sv
hw/rtl/tps_dp.sv
hw/rtl/three_level_preemptive_task_scheduler.sv
sim/three_level_preemptive_task_scheduler_test.sv
